// ----- sv/radmom_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and saturating arithmetic for the angular moment block.
package radmom_pkg;

  localparam int NMOM   = 10;
  localparam int IDX_W  = $clog2(NMOM);
  localparam int SUM_W  = 48;
  localparam int INT_W  = 24;
  localparam int AW_W   = 16;
  localparam int COS_W  = 16;
  localparam int FW_W   = 16;
  localparam int WSHIFT = 16;
  localparam int CSHIFT = 14;
  localparam int NDIR   = 3;
  localparam int NPRS   = 6;

  // Weighted intensity keeps the width of the intensity after the Q0.16 scaling.
  localparam int IRW_W  = INT_W + AW_W - WSHIFT;
  localparam int DIRP_W = IRW_W + 1 + COS_W;
  localparam int DIR_W  = DIRP_W - CSHIFT;
  localparam int PRSP_W = DIR_W + COS_W;
  localparam int PRS_W  = PRSP_W - CSHIFT;
  localparam int SCLP_W = SUM_W + FW_W + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NMOM - 1);

  // Positions of the moments in the sum arrays.
  localparam int M_ENERGY   = 0;
  localparam int M_FLUX_X   = 1;
  localparam int M_FLUX_Y   = 2;
  localparam int M_FLUX_Z   = 3;
  localparam int M_PRESS_XX = 4;
  localparam int M_PRESS_YY = 5;
  localparam int M_PRESS_ZZ = 6;
  localparam int M_PRESS_XY = 7;
  localparam int M_PRESS_XZ = 8;
  localparam int M_PRESS_YZ = 9;

  // Each pressure entry is one flux term times one cosine.
  localparam int PRS_DIR [NPRS] = '{0, 1, 2, 0, 0, 1};
  localparam int PRS_COS [NPRS] = '{0, 1, 2, 1, 2, 2};

  typedef enum logic [1:0] {
    KIND_ANGLE,
    KIND_BIN_END,
    KIND_CELL_END
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IRW,
    S_DIR,
    S_PRS,
    S_ACC,
    S_SCALE,
    S_FOLD,
    S_EMIT
  } back_state_t;

  typedef struct packed {
    logic [INT_W-1:0]        intensity;
    logic [AW_W-1:0]         angle_weight;
    logic signed [COS_W-1:0] cos_x;
    logic signed [COS_W-1:0] cos_y;
    logic signed [COS_W-1:0] cos_z;
    logic [FW_W-1:0]         freq_weight;
    kind_t                   kind;
  } item_t;

  typedef struct packed {
    logic fold;
    logic emit;
  } back_stat_t;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [NMOM-1:0] moments_t;

  function automatic sum_t add_sat(input sum_t a, input sum_t b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      add_sat = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      add_sat = s[SUM_W-1:0];
    end
  endfunction

endpackage

// ----- sv/radmom_front.sv -----
`timescale 1ns / 1ps
// Front end: takes angle samples, classifies them and holds them in a short queue.
module radmom_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [radmom_pkg::INT_W-1:0]        intensity,
  input  logic [radmom_pkg::AW_W-1:0]         angle_weight,
  input  logic signed [radmom_pkg::COS_W-1:0] cos_x,
  input  logic signed [radmom_pkg::COS_W-1:0] cos_y,
  input  logic signed [radmom_pkg::COS_W-1:0] cos_z,
  input  logic [radmom_pkg::FW_W-1:0]         freq_weight,
  input  logic                                last_angle,
  input  logic                                last_frequency,
  output logic                                q_valid,
  output radmom_pkg::item_t                   q_item,
  input  logic                                q_pop
);
  import radmom_pkg::*;

  item_t             q_mem [QDEPTH];
  item_t             in_item;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;

  // The last frequency flag only counts on the last angle of a bin.
  always_comb begin
    in_item.intensity    = intensity;
    in_item.angle_weight = angle_weight;
    in_item.cos_x        = cos_x;
    in_item.cos_y        = cos_y;
    in_item.cos_z        = cos_z;
    in_item.freq_weight  = freq_weight;
    if (!last_angle) begin
      in_item.kind = KIND_ANGLE;
    end else if (last_frequency) begin
      in_item.kind = KIND_CELL_END;
    end else begin
      in_item.kind = KIND_BIN_END;
    end
  end

  assign in_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end
  end

endmodule

// ----- sv/radmom_back.sv -----
`timescale 1ns / 1ps
// Back end: multiplies, angle and cell accumulation, frequency folding and the result register.
module radmom_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  radmom_pkg::item_t      q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output radmom_pkg::moments_t   moments,
  output radmom_pkg::back_stat_t stat
);
  import radmom_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic        emit_load;

  item_t                    cur;
  logic [IRW_W-1:0]         irw;
  logic signed [DIR_W-1:0]  dir [NDIR];
  logic signed [PRS_W-1:0]  prs [NPRS];
  logic signed [SCLP_W-1:0] scale_prod;
  logic [IDX_W-1:0]         idx;
  sum_t                     angle_sums [NMOM];
  sum_t                     cell_sums [NMOM];

  logic [INT_W+AW_W-1:0]    irw_prod;
  logic signed [COS_W-1:0]  cosv [NDIR];
  logic signed [DIRP_W-1:0] dir_prod [NDIR];
  logic signed [PRSP_W-1:0] prs_prod [NPRS];
  sum_t                     contrib [NMOM];
  sum_t                     scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_IRW;
        end
      end
      S_IRW: state_next = S_DIR;
      S_DIR: state_next = S_PRS;
      S_PRS: state_next = S_ACC;
      S_ACC: begin
        unique case (cur.kind)
          KIND_ANGLE: begin
            if (q_valid) begin
              q_pop      = 1'b1;
              state_next = S_IRW;
            end else begin
              state_next = S_IDLE;
            end
          end
          KIND_BIN_END, KIND_CELL_END: state_next = S_SCALE;
          default: state_next = S_IDLE;
        endcase
      end
      S_SCALE: state_next = S_FOLD;
      S_FOLD: begin
        if (idx != IDX_LAST) begin
          state_next = S_SCALE;
        end else if (cur.kind == KIND_CELL_END) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          emit_load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign stat.fold = (state == S_SCALE) || (state == S_FOLD);
  assign stat.emit = (state == S_EMIT);

  // Arithmetic shifts of the products are taken as part-selects.
  assign irw_prod = cur.intensity * cur.angle_weight;
  assign cosv[0]  = cur.cos_x;
  assign cosv[1]  = cur.cos_y;
  assign cosv[2]  = cur.cos_z;
  assign scaled   = scale_prod[SUM_W+WSHIFT-1:WSHIFT];

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      dir_prod[k] = $signed({1'b0, irw}) * cosv[k];
    end
    for (int k = 0; k < NPRS; k++) begin
      prs_prod[k] = dir[PRS_DIR[k]] * cosv[PRS_COS[k]];
    end
    contrib[M_ENERGY] = {{(SUM_W-IRW_W){1'b0}}, irw};
    for (int k = 0; k < NDIR; k++) begin
      contrib[M_FLUX_X+k] = {{(SUM_W-DIR_W){dir[k][DIR_W-1]}}, dir[k]};
    end
    for (int k = 0; k < NPRS; k++) begin
      contrib[M_PRESS_XX+k] = {{(SUM_W-PRS_W){prs[k][PRS_W-1]}}, prs[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == S_IRW) begin
      irw <= irw_prod[INT_W+AW_W-1:WSHIFT];
    end
    if (state == S_DIR) begin
      for (int k = 0; k < NDIR; k++) begin
        dir[k] <= dir_prod[k][DIRP_W-1:CSHIFT];
      end
    end
    if (state == S_PRS) begin
      for (int k = 0; k < NPRS; k++) begin
        prs[k] <= prs_prod[k][PRSP_W-1:CSHIFT];
      end
    end
    if (state == S_ACC) begin
      idx <= '0;
    end else if (state == S_FOLD) begin
      idx <= idx + 1'b1;
    end
    if (state == S_SCALE) begin
      scale_prod <= angle_sums[idx] * $signed({1'b0, cur.freq_weight});
    end
    if (emit_load) begin
      for (int i = 0; i < NMOM; i++) begin
        moments[i] <= cell_sums[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NMOM; i++) begin
        angle_sums[i] <= '0;
        cell_sums[i]  <= '0;
      end
    end else begin
      if (state == S_ACC) begin
        for (int i = 0; i < NMOM; i++) begin
          angle_sums[i] <= add_sat(angle_sums[i], contrib[i]);
        end
      end
      if (state == S_FOLD) begin
        cell_sums[idx]  <= add_sat(cell_sums[idx], scaled);
        angle_sums[idx] <= '0;
      end
      if (emit_load) begin
        for (int i = 0; i < NMOM; i++) begin
          cell_sums[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- sv/radiation_angular_moments.sv -----
`timescale 1ns / 1ps
// Top level of the angular moment block: front queue, back end and output ports.
// Each request is one angle sample of one frequency bin of a cell. An ordinary sample
// goes through the back end in order (weighting, flux and pressure multiplies, then
// accumulation), and the next sample is taken only once it is accumulated. The last
// sample of a bin then has the ten angle sums scaled by the frequency weight and
// folded into the cell sums through a single shared multiplier, a scale and a fold step
// per moment, and the back end then passes through idle before it takes the next sample.
// The last sample of a cell then also loads the result register, waiting while an
// earlier result has not been taken. A two-entry queue in front accepts requests while
// the back end is busy. All sums saturate to 48 bits.
module radiation_angular_moments (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [radmom_pkg::INT_W-1:0]        intensity,
  input  logic [radmom_pkg::AW_W-1:0]         angle_weight,
  input  logic signed [radmom_pkg::COS_W-1:0] cos_x,
  input  logic signed [radmom_pkg::COS_W-1:0] cos_y,
  input  logic signed [radmom_pkg::COS_W-1:0] cos_z,
  input  logic [radmom_pkg::FW_W-1:0]         freq_weight,
  input  logic                                last_angle,
  input  logic                                last_frequency,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [radmom_pkg::SUM_W-1:0] energy,
  output logic signed [radmom_pkg::SUM_W-1:0] flux_x,
  output logic signed [radmom_pkg::SUM_W-1:0] flux_y,
  output logic signed [radmom_pkg::SUM_W-1:0] flux_z,
  output logic signed [radmom_pkg::SUM_W-1:0] press_xx,
  output logic signed [radmom_pkg::SUM_W-1:0] press_yy,
  output logic signed [radmom_pkg::SUM_W-1:0] press_zz,
  output logic signed [radmom_pkg::SUM_W-1:0] press_xy,
  output logic signed [radmom_pkg::SUM_W-1:0] press_xz,
  output logic signed [radmom_pkg::SUM_W-1:0] press_yz
);
  import radmom_pkg::*;

  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  moments_t   moments;
  back_stat_t stat;

  radmom_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .intensity      (intensity),
    .angle_weight   (angle_weight),
    .cos_x          (cos_x),
    .cos_y          (cos_y),
    .cos_z          (cos_z),
    .freq_weight    (freq_weight),
    .last_angle     (last_angle),
    .last_frequency (last_frequency),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  radmom_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .moments   (moments),
    .stat      (stat)
  );

  assign energy   = moments[M_ENERGY];
  assign flux_x   = moments[M_FLUX_X];
  assign flux_y   = moments[M_FLUX_Y];
  assign flux_z   = moments[M_FLUX_Z];
  assign press_xx = moments[M_PRESS_XX];
  assign press_yy = moments[M_PRESS_YY];
  assign press_zz = moments[M_PRESS_ZZ];
  assign press_xy = moments[M_PRESS_XY];
  assign press_xz = moments[M_PRESS_XZ];
  assign press_yz = moments[M_PRESS_YZ];

  // The front only refuses requests when its queue holds something.
  a_ready_means_queued: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input refused while the queue is empty");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_no_pop_in_fold: assert property (@(posedge clk) disable iff (rst)
    stat.fold |-> !q_pop)
    else $error("new sample taken during the frequency fold");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stat.emit))
    else $error("result appeared without a cell end");

endmodule
